[sv/rrts_pkg.sv]
`default_nettype none
package rrts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned WORK_W        = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned SLICE_W       = 20;
  localparam int unsigned QUANTUM_W     = 16;
  localparam int unsigned RESULT_SLOTS  = 16;
  localparam int unsigned NRES_W        = $clog2(RESULT_SLOTS + 1);

  localparam logic [SLICE_W-1:0]   SLICE_MAX     = '1;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST   = QUANTUM_W'(1);
  localparam logic [ID_W-1:0]      NEXT_ID_RST   = ID_W'(1);

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic add;
    logic run_init;
    logic skip;
    logic visit;
  } cmd_t;

  typedef struct packed {
    logic is_empty;
    logic cur_valid;
    logic finish;
  } status_t;

endpackage
`default_nettype wire

[sv/rrts_ram.sv]
`default_nettype none
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[sv/rrts_datapath.sv]
`default_nettype none
module rrts_datapath #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rrts_pkg::cmd_t                     cmd_i,
  output rrts_pkg::status_t                       status_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [rrts_pkg::QUANTUM_W-1:0]     cfg_wdata_i,
  input  wire logic [rrts_pkg::WORK_W-1:0]        work_amount_i,
  output logic                                    result_valid_o,
  output logic      [rrts_pkg::ID_W-1:0]          task_id_o,
  output logic      [rrts_pkg::SLICE_W-1:0]       slice_number_o,
  output logic                                    last_done_o
);

  localparam int unsigned CW = $clog2(MAX_TASKS);
  localparam int unsigned NW = $clog2(MAX_TASKS + 1);
  localparam int unsigned DW = rrts_pkg::WORK_W + rrts_pkg::ID_W;

  logic [rrts_pkg::QUANTUM_W-1:0] quantum_q;
  logic [rrts_pkg::ID_W-1:0]      next_id_q;
  logic [NW-1:0]                  count_q;
  logic [NW-1:0]                  left_q;
  logic [MAX_TASKS-1:0]           valid_q;
  logic [CW-1:0]                  cursor_q, cursor_d;
  logic [rrts_pkg::SLICE_W-1:0]   slice_q, slice_d;
  logic [rrts_pkg::NRES_W-1:0]    nres_q;

  logic                           res_valid_q;
  logic [rrts_pkg::ID_W-1:0]      res_id_q;
  logic [rrts_pkg::SLICE_W-1:0]   res_slice_q;
  logic                           res_last_q;

  logic [DW-1:0]                  rd_data;
  logic [rrts_pkg::WORK_W-1:0]    rd_work;
  logic [rrts_pkg::ID_W-1:0]      rd_id;
  logic [rrts_pkg::QUANTUM_W-1:0] q_eff;
  logic                           complete;
  logic                           full;
  logic                           add_ok;
  logic [NW-1:0]                  last_cnt;
  logic                           ram_we;
  logic [CW-1:0]                  ram_waddr;
  logic [DW-1:0]                  ram_wdata;
  logic                           emit;
  logic                           is_last;

  assign rd_work  = rd_data[rrts_pkg::WORK_W-1:0];
  assign rd_id    = rd_data[rrts_pkg::WORK_W +: rrts_pkg::ID_W];
  // a zero quantum acts as one so a run always drains
  assign q_eff    = (quantum_q == '0) ? rrts_pkg::QUANTUM_W'(1) : quantum_q;
  assign complete = (rd_work <= q_eff);
  assign full     = (count_q == NW'(MAX_TASKS));
  assign add_ok   = cmd_i.add && !full;
  assign last_cnt = count_q - NW'(1);

  assign cursor_d = (cursor_q == last_cnt[CW-1:0]) ? '0 : cursor_q + CW'(1);
  assign slice_d  = (slice_q == rrts_pkg::SLICE_MAX) ? slice_q
                                                    : slice_q + rrts_pkg::SLICE_W'(1);

  assign emit    = cmd_i.visit && complete && (nres_q < rrts_pkg::NRES_W'(rrts_pkg::RESULT_SLOTS));
  assign is_last = (left_q == NW'(1))
                || (nres_q == rrts_pkg::NRES_W'(rrts_pkg::RESULT_SLOTS - 1));

  assign ram_we    = add_ok || (cmd_i.visit && !complete);
  assign ram_waddr = cmd_i.add ? count_q[CW-1:0] : cursor_q;
  assign ram_wdata = cmd_i.add ? {next_id_q, work_amount_i}
                               : {rd_id, rd_work - q_eff};

  rrts_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cursor_q),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= rrts_pkg::QUANTUM_RST;
      next_id_q   <= rrts_pkg::NEXT_ID_RST;
      count_q     <= '0;
      left_q      <= '0;
      valid_q     <= '0;
      cursor_q    <= '0;
      slice_q     <= '0;
      nres_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (add_ok) begin
        valid_q[count_q[CW-1:0]] <= 1'b1;
        count_q   <= count_q + NW'(1);
        next_id_q <= next_id_q + rrts_pkg::ID_W'(1);
      end
      if (cmd_i.run_init) begin
        left_q   <= count_q;
        cursor_q <= '0;
        slice_q  <= '0;
        nres_q   <= '0;
      end
      if (cmd_i.skip) begin
        cursor_q <= cursor_d;
      end
      if (cmd_i.visit) begin
        cursor_q <= cursor_d;
        slice_q  <= slice_d;
        if (complete) begin
          valid_q[cursor_q] <= 1'b0;
          left_q <= left_q - NW'(1);
          if (left_q == NW'(1)) begin
            count_q <= '0;
          end
        end
        if (emit) begin
          nres_q <= nres_q + rrts_pkg::NRES_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_id_q    <= rd_id;
      res_slice_q <= slice_d;
      res_last_q  <= is_last;
    end
  end

  assign status_o.is_empty  = (count_q == '0);
  assign status_o.cur_valid = valid_q[cursor_q];
  assign status_o.finish    = complete && (left_q == NW'(1));

  assign result_valid_o = res_valid_q;
  assign task_id_o      = res_id_q;
  assign slice_number_o = res_slice_q;
  assign last_done_o    = res_last_q;

endmodule
`default_nettype wire

[sv/rrts_ctrl.sv]
`default_nettype none
module rrts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              req_type_i,
  input  wire rrts_pkg::status_t status_i,
  output rrts_pkg::cmd_t         cmd_o,
  output logic                   busy
);

  rrts_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = start && (state_q == rrts_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::ST_IDLE: begin
        if (accept && req_type_i == rrts_pkg::REQ_RUN && !status_i.is_empty) begin
          state_d = rrts_pkg::ST_SCAN;
        end
      end
      rrts_pkg::ST_SCAN: begin
        if (status_i.cur_valid) begin
          state_d = rrts_pkg::ST_EXEC;
        end
      end
      rrts_pkg::ST_EXEC: begin
        state_d = status_i.finish ? rrts_pkg::ST_IDLE : rrts_pkg::ST_SCAN;
      end
      default: begin
        state_d = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      rrts_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd_o.add      = accept && (req_type_i == rrts_pkg::REQ_ADD);
        cmd_o.run_init = accept && (req_type_i == rrts_pkg::REQ_RUN) && !status_i.is_empty;
      end
      rrts_pkg::ST_SCAN: begin
        // empty slots are stepped over without counting a slice
        cmd_o.skip = !status_i.cur_valid;
      end
      rrts_pkg::ST_EXEC: begin
        cmd_o.visit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/round_robin_task_scheduler_core.sv]
`default_nettype none
// round-robin task scheduler with a configurable time quantum
// requests enter on start/req_type_i/work_amount_i and are taken on a clock
// edge where start is high and busy is low
// an add request (req_type_i = 0) queues a task with the next 8-bit id and
// gives no result; it is dropped when the table is full
// a run request (req_type_i = 1) visits the queued tasks in insertion order,
// taking time_quantum from each, until all have finished; busy stays high
// meanwhile. each visit reads the task ram, then updates the task, and each
// empty slot is stepped over without a visit; a run on an empty queue is taken
// but the block stays idle
// each finished task is shown for one cycle with result_valid_o high, task_id_o,
// slice_number_o and last_done_o; the receiver cannot stall, results are
// never held. the final result appears in the cycle busy drops
// time_quantum is written by cfg_we_i/cfg_wdata_i (zero acts as one); the user
// must write it only while idle, the block does not enforce this. reset empties
// the queue, sets the id counter and the quantum to 1; there is no clearing pass
module round_robin_task_scheduler_core #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           req_type_i,
  input  wire logic [rrts_pkg::WORK_W-1:0]    work_amount_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrts_pkg::QUANTUM_W-1:0] cfg_wdata_i,
  output logic                                result_valid_o,
  output logic      [rrts_pkg::ID_W-1:0]      task_id_o,
  output logic      [rrts_pkg::SLICE_W-1:0]   slice_number_o,
  output logic                                last_done_o
);

  rrts_pkg::cmd_t    cmd;
  rrts_pkg::status_t status;

  rrts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .req_type_i(req_type_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  rrts_datapath #(
    .MAX_TASKS(MAX_TASKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .work_amount_i (work_amount_i),
    .result_valid_o(result_valid_o),
    .task_id_o     (task_id_o),
    .slice_number_o(slice_number_o),
    .last_done_o   (last_done_o)
  );

endmodule
`default_nettype wire

[sv/rrts_checker.sv]
`default_nettype none
module rrts_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic req_type_i,
  input wire logic result_valid_o,
  input wire logic last_done_o
);

  // results only come out of a run in progress
  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a run in progress");

  // a non-final result means the run continues
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_done_o |-> busy)
    else $error("run ended without a final result");

  // nothing follows the final result of a run
  a_last_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_done_o |=> !result_valid_o)
    else $error("result after the final one");

  // busy only rises on an accepted run request
  a_busy_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && $past(req_type_i))
    else $error("busy without a run request");

  // an add request never blocks the next one
  a_add_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_type_i |=> !busy)
    else $error("add request left the block busy");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .req_type_i    (req_type_i),
  .result_valid_o(result_valid_o),
  .last_done_o   (last_done_o)
);
`default_nettype wire

[tb/tb_round_robin_task_scheduler_core.sv]
`default_nettype none
module tb_round_robin_task_scheduler_core;

  localparam int unsigned TASKS      = rrts_pkg::MAX_TASKS_DEF;
  localparam int unsigned QUIET_MAX  = 50000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REQS = 36;

  typedef struct packed {
    logic [rrts_pkg::ID_W-1:0]    id;
    logic [rrts_pkg::SLICE_W-1:0] slice;
    logic                         last;
  } completion_t;

  // predicts completions of a run and checks them against the block
  class sched_scoreboard;
    logic [rrts_pkg::QUANTUM_W-1:0] quantum;
    logic [rrts_pkg::WORK_W-1:0]    work_left [TASKS];
    logic [rrts_pkg::ID_W-1:0]      ids       [TASKS];
    bit                             live      [TASKS];
    int unsigned                    queued;
    logic [rrts_pkg::ID_W-1:0]      next_id;
    completion_t                    due_completions[$];
    int unsigned                    errors, checked, adds, drops, runs;

    function new();
      quantum = rrts_pkg::QUANTUM_RST;
      next_id = rrts_pkg::NEXT_ID_RST;
      queued  = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void set_quantum(logic [rrts_pkg::QUANTUM_W-1:0] value);
      quantum = value;
    endfunction

    function int unsigned pending();
      return due_completions.size();
    endfunction

    function void note_request(logic req, logic [rrts_pkg::WORK_W-1:0] work);
      int unsigned q, left, slice, n;
      completion_t held;
      bit have;
      if (req == rrts_pkg::REQ_ADD) begin
        if (queued < TASKS) begin
          work_left[queued] = work;
          ids[queued]       = next_id;
          live[queued]      = 1'b1;
          queued++;
          next_id++;
          adds++;
        end else begin
          drops++;
        end
        return;
      end
      runs++;
      q     = (quantum == '0) ? 1 : quantum;
      left  = queued;
      slice = 0;
      n     = 0;
      have  = 1'b0;
      while (left > 0) begin
        for (int i = 0; i < TASKS && left > 0; i++) begin
          if (!live[i]) continue;
          if (slice < rrts_pkg::SLICE_MAX) slice++;
          if (work_left[i] <= q) begin
            live[i] = 1'b0;
            left--;
            if (n < rrts_pkg::RESULT_SLOTS) begin
              if (have) due_completions.push_back(held);
              held = '{id: ids[i], slice: slice[rrts_pkg::SLICE_W-1:0], last: 1'b0};
              have = 1'b1;
              n++;
            end
          end else begin
            work_left[i] = work_left[i] - rrts_pkg::WORK_W'(q);
          end
        end
      end
      // only the final completion of a run carries the last flag
      if (have) begin
        held.last = 1'b1;
        due_completions.push_back(held);
      end
      queued = 0;
    endfunction

    function void check_completion(logic [rrts_pkg::ID_W-1:0] id,
                                   logic [rrts_pkg::SLICE_W-1:0] slice,
                                   logic last);
      completion_t exp;
      if (due_completions.size() == 0) begin
        errors++;
        $display("%0t: unexpected completion id=%0d slice=%0d last=%0b",
                 $time, id, slice, last);
        return;
      end
      exp = due_completions.pop_front();
      checked++;
      if (id !== exp.id) begin
        errors++;
        $display("%0t: task_id expected %0d actual %0d", $time, exp.id, id);
      end
      if (slice !== exp.slice) begin
        errors++;
        $display("%0t: slice_number expected %0d actual %0d", $time, exp.slice, slice);
      end
      if (last !== exp.last) begin
        errors++;
        $display("%0t: last_done expected %0b actual %0b", $time, exp.last, last);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic                           req_type_i;
  logic [rrts_pkg::WORK_W-1:0]    work_amount_i;
  logic                           cfg_we_i;
  logic [rrts_pkg::QUANTUM_W-1:0] cfg_wdata_i;
  logic                           result_valid_o;
  logic [rrts_pkg::ID_W-1:0]      task_id_o;
  logic [rrts_pkg::SLICE_W-1:0]   slice_number_o;
  logic                           last_done_o;

  sched_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     quiet;
  int unsigned     n_cfg;
  logic [rrts_pkg::QUANTUM_W-1:0] cur_quantum;

  round_robin_task_scheduler_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .work_amount_i  (work_amount_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .task_id_o      (task_id_o),
    .slice_number_o (slice_number_o),
    .last_done_o    (last_done_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_completion(task_id_o, slice_number_o, last_done_o);
    end
  end

  // watchdog on cycles where no request is taken and no completion shows up
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("FAIL round_robin_task_scheduler_core");
        $finish;
      end
    end
  end

  task automatic issue(logic req, logic [rrts_pkg::WORK_W-1:0] work);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= req;
    work_amount_i <= work;
    do @(posedge clk_i); while (busy);
    sb.note_request(req, work);
  endtask

  // hold off new requests until every completion is in and the block is idle
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [rrts_pkg::QUANTUM_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_quantum(value);
    cur_quantum = value;
    n_cfg++;
  endtask

  // keeps visits per task small so runs stay short
  function automatic logic [rrts_pkg::WORK_W-1:0] pick_work(
      logic [rrts_pkg::QUANTUM_W-1:0] q);
    int unsigned eff, top;
    eff = (q == '0) ? 1 : q;
    top = eff * 12;
    if (top > 65535) top = 65535;
    if ($urandom_range(4) == 0) begin
      return rrts_pkg::WORK_W'(eff * $urandom_range(0, top / eff));
    end
    return rrts_pkg::WORK_W'($urandom_range(0, top));
  endfunction

  initial begin
    int unsigned sent, n_adds;
    logic [rrts_pkg::QUANTUM_W-1:0] phase_q [PHASES];
    sb            = new();
    quiet         = 0;
    n_cfg         = 0;
    idle_pct      = 0;
    cur_quantum   = rrts_pkg::QUANTUM_RST;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = rrts_pkg::REQ_ADD;
    work_amount_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty run, zero work, quantum at reset value
    issue(rrts_pkg::REQ_RUN, 16'd0);
    issue(rrts_pkg::REQ_ADD, 16'd0);
    issue(rrts_pkg::REQ_ADD, 16'd3);
    issue(rrts_pkg::REQ_ADD, 16'd2);
    issue(rrts_pkg::REQ_RUN, 16'd0);
    // zero quantum behaves as one
    write_quantum(16'd0);
    issue(rrts_pkg::REQ_ADD, 16'd2);
    issue(rrts_pkg::REQ_RUN, 16'd0);
    // fill the table, one add past full is dropped
    write_quantum(16'd65534);
    for (int i = 0; i < TASKS + 1; i++) begin
      case (i % 3)
        0: issue(rrts_pkg::REQ_ADD, 16'hffff);
        1: issue(rrts_pkg::REQ_ADD, 16'h0000);
        default: issue(rrts_pkg::REQ_ADD, 16'hfffe);
      endcase
    end
    issue(rrts_pkg::REQ_RUN, 16'd0);

    phase_q = '{16'd1, 16'd65535, 16'd5, 16'd0, 16'd700,
                rrts_pkg::QUANTUM_W'($urandom_range(1, 65535)), 16'd65534, 16'd2};
    for (int p = 0; p < PHASES; p++) begin
      write_quantum(phase_q[p]);
      case (p % 4)
        1:       idle_pct = 54;
        3:       idle_pct = 10;
        default: idle_pct = 0;
      endcase
      sent = 0;
      while (sent < PHASE_REQS) begin
        if ($urandom_range(19) == 0) begin
          // stray run, often on an empty queue
          issue(rrts_pkg::REQ_RUN, rrts_pkg::WORK_W'($urandom));
          sent++;
        end else begin
          n_adds = ($urandom_range(9) == 0) ? TASKS + $urandom_range(1, 3)
                                           : $urandom_range(1, TASKS);
          repeat (n_adds) begin
            issue(rrts_pkg::REQ_ADD,
                  (cur_quantum >= 16'd4096 && $urandom_range(1) == 1)
                  ? rrts_pkg::WORK_W'($urandom) : pick_work(cur_quantum));
          end
          issue(rrts_pkg::REQ_RUN, rrts_pkg::WORK_W'($urandom));
          sent += n_adds + 1;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    sb.errors += sb.pending();
    $display("covered %0d adds (%0d dropped on a full table) and %0d runs over %0d quantum writes",
             sb.adds, sb.drops, sb.runs, n_cfg);
    $display("checked %0d completions, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS round_robin_task_scheduler_core");
    end else begin
      $display("FAIL round_robin_task_scheduler_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/rrts_datapath.sv
sv/rrts_ctrl.sv
sv/round_robin_task_scheduler_core.sv
sv/rrts_checker.sv
tb/tb_round_robin_task_scheduler_core.sv
